// ----- hdl/bsfg_pkg.sv -----
// Package with widths, opcodes, constants and types of the budgeted stereo fade gate.
`default_nettype none
package bsfg_pkg;

  localparam int OPC_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int BUDGET_W = 16;
  localparam int US_W     = 24;
  localparam int RATE_W   = 18;
  localparam int ENV_W    = 16;
  localparam int Q_FRAC   = 15;
  // Up to rate 192000 a fade of ceil(192000 * (2**24 - 1) / 1e6) samples fits in 22 bits.
  localparam int LEN_W    = 22;
  localparam int RPROD_W  = RATE_W + 1 + US_W;
  localparam int SPROD_W  = SAMPLE_W + Q_FRAC;

  localparam logic [OPC_W-1:0] OPC_SAMPLE    = 3'd0;
  localparam logic [OPC_W-1:0] OPC_LOAD      = 3'd1;
  localparam logic [OPC_W-1:0] OPC_FADE      = 3'd2;
  localparam logic [OPC_W-1:0] OPC_ENV_RESET = 3'd3;
  localparam logic [OPC_W-1:0] OPC_STOP      = 3'd4;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd44100;
  localparam logic [ENV_W-1:0]   ENV_UNITY   = 16'h8000;
  localparam logic [RPROD_W-1:0] US_PER_S_M1 = 43'd999999;
  localparam logic [LEN_W-1:0]   US_PER_S    = 22'd1000000;

  typedef struct packed {
    logic [OPC_W-1:0]           opcode;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [BUDGET_W-1:0]        budget_count;
    logic [US_W-1:0]            fade_us;
  } item_t;

endpackage
`default_nettype wire

// ----- hdl/bsfg_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface bsfg_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [bsfg_pkg::OPC_W-1:0]              opcode;
  logic signed [bsfg_pkg::SAMPLE_W-1:0]    left_in;
  logic signed [bsfg_pkg::SAMPLE_W-1:0]    right_in;
  logic                                    sink_ready;
  logic [bsfg_pkg::BUDGET_W-1:0]           budget_count;
  logic [bsfg_pkg::US_W-1:0]               fade_us;

  modport source (output valid, opcode, left_in, right_in, sink_ready, budget_count, fade_us,
                  input ready);
  modport sink (input valid, opcode, left_in, right_in, sink_ready, budget_count, fade_us,
                output ready);
endinterface

interface bsfg_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bsfg_pkg::SAMPLE_W-1:0]    left_out;
  logic signed [bsfg_pkg::SAMPLE_W-1:0]    right_out;
  logic                                    accepted;
  logic                                    fade_done;
  logic [bsfg_pkg::BUDGET_W-1:0]           budget_left;

  modport source (output valid, left_out, right_out, accepted, fade_done, budget_left,
                  input ready);
  modport sink (input valid, left_out, right_out, accepted, fade_done, budget_left,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/budgeted_stereo_fade_gate.sv -----
// Top level of the budgeted stereo fade gate: control, state and result register.
// Each item is taken one at a time. Control items, refused samples and passed samples at
// unity gain go from the item register straight to the result register. Below unity the two
// channels go through bit-serial multipliers, one envelope bit per cycle. A begin-fade item
// with a nonzero time runs a 24-step serial rate-times-time product and two 43-step serial
// divisions (length in samples, then the step). The next item is taken while a finished
// result still waits in the output register.
`default_nettype none
module budgeted_stereo_fade_gate (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bsfg_pkg::RATE_W-1:0]   cfg_wdata_i,
  bsfg_in_if.sink                            in_ch_i,
  bsfg_out_if.source                         out_ch_o
);

  import bsfg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RMUL = 3'd2;
  localparam logic [2:0] S_LDIV = 3'd3;
  localparam logic [2:0] S_SDIV = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [RATE_W-1:0]   rate_q;
  item_t               item_q, item_d;
  logic                pass_q, pass_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [ENV_W-1:0]    new_step_q, new_step_d;

  logic [BUDGET_W-1:0] budget_q, budget_d;
  logic [ENV_W-1:0]    env_q, env_d;
  logic [ENV_W-1:0]    step_q, step_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic                active_q, active_d;
  logic                complete_q, complete_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_left_q, out_left_d;
  logic signed [SAMPLE_W-1:0] out_right_q, out_right_d;
  logic                       out_acc_q, out_acc_d;
  logic                       out_done_q, out_done_d;
  logic [BUDGET_W-1:0]        out_budget_q, out_budget_d;

  logic                in_fire;
  logic                slot_free;
  logic                commit;
  logic                smul_start;
  logic                rmul_start;
  logic                div_start;
  logic signed [SPROD_W-1:0] lprod, rprod_s;
  logic                lmul_done, rmul_s_done;
  logic signed [RPROD_W-1:0] rate_prod;
  logic                rate_done;
  logic [RPROD_W-1:0]  div_dividend;
  logic [LEN_W-1:0]    div_divisor;
  logic [RPROD_W-1:0]  div_quot;
  logic                div_done;
  logic [LEN_W-1:0]    len_calc;
  logic [ENV_W-1:0]    step_calc;
  logic [SAMPLE_W-1:0] left_rnd, right_rnd;

  assign in_ch_i.ready = (state_q == S_IDLE);
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;
  assign slot_free     = !out_valid_q || out_ch_o.ready;
  assign commit        = (state_q == S_DONE) && slot_free;

  assign smul_start = in_fire && (in_ch_i.opcode == OPC_SAMPLE) && (budget_q != '0)
                      && in_ch_i.sink_ready && !env_q[ENV_W-1];
  assign rmul_start = in_fire && (in_ch_i.opcode == OPC_FADE) && (in_ch_i.fade_us != '0);

  bsfg_serial_mul #(.A_W(SAMPLE_W), .B_W(Q_FRAC)) u_mul_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (smul_start),
    .a_i     (in_ch_i.left_in),
    .b_i     (env_q[Q_FRAC-1:0]),
    .p_o     (lprod),
    .done_o  (lmul_done)
  );

  bsfg_serial_mul #(.A_W(SAMPLE_W), .B_W(Q_FRAC)) u_mul_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (smul_start),
    .a_i     (in_ch_i.right_in),
    .b_i     (env_q[Q_FRAC-1:0]),
    .p_o     (rprod_s),
    .done_o  (rmul_s_done)
  );

  bsfg_serial_mul #(.A_W(RATE_W + 1), .B_W(US_W)) u_mul_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rmul_start),
    .a_i     ({1'b0, rate_q}),
    .b_i     (in_ch_i.fade_us),
    .p_o     (rate_prod),
    .done_o  (rate_done)
  );

  // The divider first turns rate * time into a sample count, then divides the envelope by it.
  assign div_start    = ((state_q == S_RMUL) && rate_done) || ((state_q == S_LDIV) && div_done);
  assign div_dividend = (state_q == S_RMUL) ? RPROD_W'($unsigned(rate_prod)) + US_PER_S_M1
                                            : RPROD_W'(env_q);
  assign div_divisor  = (state_q == S_RMUL) ? US_PER_S : len_calc;
  assign len_calc     = (div_quot[LEN_W-1:0] == '0) ? LEN_W'(1) : div_quot[LEN_W-1:0];
  assign step_calc    = ((div_quot[ENV_W-1:0] == '0) && (env_q != '0)) ? ENV_W'(1)
                                                                      : div_quot[ENV_W-1:0];

  bsfg_serial_div #(.N_W(RPROD_W), .D_W(LEN_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  // Rounding by half an LSB then shifting equals the upper bits plus the first dropped bit.
  assign left_rnd  = lprod[SPROD_W-1:Q_FRAC] + {{(SAMPLE_W - 1){1'b0}}, lprod[Q_FRAC-1]};
  assign right_rnd = rprod_s[SPROD_W-1:Q_FRAC] + {{(SAMPLE_W - 1){1'b0}}, rprod_s[Q_FRAC-1]};

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    pass_d     = pass_q;
    len_d      = len_q;
    new_step_d = new_step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_d.opcode       = in_ch_i.opcode;
          item_d.left         = in_ch_i.left_in;
          item_d.right        = in_ch_i.right_in;
          item_d.budget_count = in_ch_i.budget_count;
          item_d.fade_us      = in_ch_i.fade_us;
          pass_d  = (budget_q != '0) && in_ch_i.sink_ready;
          if (smul_start) begin
            state_d = S_MUL;
          end else if (rmul_start) begin
            state_d = S_RMUL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL: begin
        if (lmul_done && rmul_s_done) begin
          state_d = S_DONE;
        end
      end
      S_RMUL: begin
        if (rate_done) begin
          state_d = S_LDIV;
        end
      end
      S_LDIV: begin
        if (div_done) begin
          len_d   = len_calc;
          state_d = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_done) begin
          new_step_d = step_calc;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    budget_d     = budget_q;
    env_d        = env_q;
    step_d       = step_q;
    rem_d        = rem_q;
    active_d     = active_q;
    complete_d   = complete_q;
    out_valid_d  = out_valid_q && !out_ch_o.ready;
    out_left_d   = out_left_q;
    out_right_d  = out_right_q;
    out_acc_d    = out_acc_q;
    out_done_d   = out_done_q;
    out_budget_d = out_budget_q;
    if (commit) begin
      out_left_d  = '0;
      out_right_d = '0;
      out_acc_d   = 1'b0;
      case (item_q.opcode)
        OPC_SAMPLE: begin
          if (pass_q) begin
            out_left_d  = env_q[ENV_W-1] ? item_q.left : $signed(left_rnd);
            out_right_d = env_q[ENV_W-1] ? item_q.right : $signed(right_rnd);
            out_acc_d   = 1'b1;
            if (active_q) begin
              if (rem_q != '0) begin
                env_d = (env_q > step_q) ? env_q - step_q : '0;
                rem_d = rem_q - LEN_W'(1);
              end
              if (rem_d == '0) begin
                env_d      = '0;
                step_d     = '0;
                active_d   = 1'b0;
                complete_d = 1'b1;
              end
            end
            budget_d = budget_q - BUDGET_W'(1);
          end
        end
        OPC_LOAD: begin
          budget_d = item_q.budget_count;
        end
        OPC_FADE: begin
          if (item_q.fade_us == '0) begin
            env_d      = '0;
            step_d     = '0;
            rem_d      = '0;
            active_d   = 1'b0;
            complete_d = 1'b1;
          end else begin
            rem_d      = len_q;
            step_d     = new_step_q;
            active_d   = 1'b1;
            complete_d = 1'b0;
          end
        end
        OPC_ENV_RESET, OPC_STOP: begin
          if (item_q.opcode == OPC_STOP) begin
            budget_d = '0;
          end
          env_d      = ENV_UNITY;
          step_d     = '0;
          rem_d      = '0;
          active_d   = 1'b0;
          complete_d = 1'b0;
        end
        default: begin
        end
      endcase
      out_valid_d  = 1'b1;
      out_done_d   = complete_d;
      out_budget_d = budget_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= RATE_RESET;
      pass_q      <= 1'b0;
      budget_q    <= '0;
      env_q       <= ENV_UNITY;
      step_q      <= '0;
      rem_q       <= '0;
      active_q    <= 1'b0;
      complete_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      // A zero rate is not a valid setting and leaves the register as it was.
      if (cfg_we_i && (cfg_wdata_i != '0)) begin
        rate_q <= cfg_wdata_i;
      end
      pass_q      <= pass_d;
      budget_q    <= budget_d;
      env_q       <= env_d;
      step_q      <= step_d;
      rem_q       <= rem_d;
      active_q    <= active_d;
      complete_q  <= complete_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    len_q        <= len_d;
    new_step_q   <= new_step_d;
    out_left_q   <= out_left_d;
    out_right_q  <= out_right_d;
    out_acc_q    <= out_acc_d;
    out_done_q   <= out_done_d;
    out_budget_q <= out_budget_d;
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.left_out    = out_left_q;
  assign out_ch_o.right_out   = out_right_q;
  assign out_ch_o.accepted    = out_acc_q;
  assign out_ch_o.fade_done   = out_done_q;
  assign out_ch_o.budget_left = out_budget_q;

endmodule
`default_nettype wire

// ----- hdl/bsfg_serial_mul.sv -----
// Bit-serial shift-and-add multiplier: signed multiplicand times unsigned multiplier.
`default_nettype none
module bsfg_serial_mul #(
  parameter int A_W = 16,
  parameter int B_W = 15
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [A_W-1:0]  a_i,
  input  wire logic [B_W-1:0]         b_i,
  output logic signed [A_W+B_W-1:0]   p_o,
  output logic                        done_o
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [A_W-1:0]    a_q, a_d;
  // High part holds one guard bit; the low part shifts the multiplier out LSB first.
  logic [A_W+B_W:0]  p_q, p_d;
  logic [A_W:0]      sum;

  always_comb begin
    sum    = p_q[A_W+B_W:B_W] + (p_q[0] ? {a_q[A_W-1], a_q} : '0);
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    a_d    = a_q;
    p_d    = p_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(B_W);
      a_d    = a_i;
      p_d    = {{(A_W + 1){1'b0}}, b_i};
    end else if (busy_q) begin
      p_d   = {sum[A_W], sum, p_q[B_W-1:1]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign p_o    = p_q[A_W+B_W-1:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- hdl/bsfg_serial_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module bsfg_serial_div #(
  parameter int N_W = 43,
  parameter int D_W = 22
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [N_W-1:0]  dividend_i,
  input  wire logic [D_W-1:0]  divisor_i,
  output logic [N_W-1:0]       quotient_o,
  output logic                 done_o
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [D_W-1:0]    div_q, div_d;
  logic [D_W-1:0]    rem_q, rem_d;
  // Dividend bits leave at the top while quotient bits enter at the bottom.
  logic [N_W-1:0]    sh_q, sh_d;
  logic [D_W:0]      trial;
  logic              fits;

  always_comb begin
    trial  = {rem_q, sh_q[N_W-1]};
    fits   = (trial >= {1'b0, div_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    div_d  = div_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(N_W);
      div_d  = divisor_i;
      rem_d  = '0;
      sh_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? D_W'(trial - {1'b0, div_q}) : trial[D_W-1:0];
      sh_d  = {sh_q[N_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign quotient_o = sh_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

// ----- dv/budgeted_stereo_fade_gate_checker.sv -----
// Checker for the budgeted stereo fade gate: predicts every result and compares it on transfer.
`timescale 1ns / 1ps
module budgeted_stereo_fade_gate_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bsfg_pkg::RATE_W-1:0] cfg_wdata_i,
  bsfg_in_if                          in_mon_i,
  bsfg_out_if                         out_mon_i,
  output int                          err_cnt_o,
  output int                          pending_o
);

  import bsfg_pkg::*;

  localparam longint ROUND_HALF = 16384;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       accepted;
    logic                       fade_done;
    logic [BUDGET_W-1:0]        budget_left;
  } gate_result_t;

  gate_result_t        gated_due_q[$];
  logic [RATE_W-1:0]   rate;
  logic [BUDGET_W-1:0] budget;
  logic [ENV_W-1:0]    env;
  logic [ENV_W-1:0]    step;
  logic [31:0]         remaining;
  logic                fade_on;
  logic                fade_end;
  int                  errors = 0;

  task automatic clear_envelope();
    env       = ENV_UNITY;
    step      = '0;
    remaining = '0;
    fade_on   = 1'b0;
    fade_end  = 1'b0;
  endtask

  // Q15 gain with round-half-up and an arithmetic shift; unity passes the sample untouched.
  function automatic logic [SAMPLE_W-1:0] apply_gain(input logic signed [SAMPLE_W-1:0] s,
                                                    input logic [ENV_W-1:0] g);
    longint prod;
    if (g >= ENV_UNITY) return s;
    prod = longint'(s) * longint'(g) + ROUND_HALF;
    prod = prod >>> Q_FRAC;
    return prod[SAMPLE_W-1:0];
  endfunction

  task automatic start_fade(input logic [US_W-1:0] us);
    longint unsigned span;
    if (us == '0) begin
      // A zero fade time mutes at once.
      env       = '0;
      step      = '0;
      remaining = '0;
      fade_on   = 1'b0;
      fade_end  = 1'b1;
    end else begin
      span = (64'(rate) * 64'(us) + 64'(US_PER_S_M1)) / 64'(US_PER_S);
      if (span == 0) span = 1;
      remaining = span[31:0];
      step      = ENV_W'(32'(env) / remaining);
      if (step == '0 && env != '0) step = ENV_W'(1);
      fade_on  = 1'b1;
      fade_end = 1'b0;
    end
  endtask

  task automatic predict_gate_result();
    gate_result_t res;
    res = '0;
    case (in_mon_i.opcode)
      OPC_SAMPLE: begin
        if (budget != '0 && in_mon_i.sink_ready) begin
          res.left     = apply_gain(in_mon_i.left_in, env);
          res.right    = apply_gain(in_mon_i.right_in, env);
          res.accepted = 1'b1;
          if (fade_on) begin
            if (remaining > 0) begin
              env       = (env > step) ? env - step : '0;
              remaining = remaining - 1;
            end
            if (remaining == 0) begin
              env      = '0;
              step     = '0;
              fade_on  = 1'b0;
              fade_end = 1'b1;
            end
          end
          budget = budget - 1'b1;
        end
      end
      OPC_LOAD:      budget = in_mon_i.budget_count;
      OPC_FADE:      start_fade(in_mon_i.fade_us);
      OPC_ENV_RESET: clear_envelope();
      OPC_STOP: begin
        budget = '0;
        clear_envelope();
      end
      default: ;
    endcase
    res.fade_done   = fade_end;
    res.budget_left = budget;
    gated_due_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gate_result_t got;
    gate_result_t want;
    if (!rst_ni) begin
      rate   = RATE_RESET;
      budget = '0;
      clear_envelope();
      gated_due_q.delete();
      pending_o <= 0;
      err_cnt_o <= errors;
    end else begin
      // A zero rate write is dropped by the block.
      if (cfg_we_i && cfg_wdata_i != '0) rate = cfg_wdata_i;
      if (in_mon_i.valid && in_mon_i.ready) predict_gate_result();
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = '{out_mon_i.left_out, out_mon_i.right_out, out_mon_i.accepted,
                out_mon_i.fade_done, out_mon_i.budget_left};
        if (gated_due_q.size() == 0) begin
          errors++;
          $display({"%0t: unexpected result: expected none, ",
                    "actual L=%0d R=%0d acc=%b done=%b bud=%0d"},
                   $time, got.left, got.right, got.accepted, got.fade_done, got.budget_left);
        end else begin
          want = gated_due_q.pop_front();
          if (got !== want) begin
            errors++;
            $display({"%0t: result mismatch: expected L=%0d R=%0d acc=%b done=%b bud=%0d, ",
                      "actual L=%0d R=%0d acc=%b done=%b bud=%0d"},
                     $time, want.left, want.right, want.accepted, want.fade_done,
                     want.budget_left, got.left, got.right, got.accepted, got.fade_done,
                     got.budget_left);
          end
        end
      end
      pending_o <= gated_due_q.size();
      err_cnt_o <= errors;
    end
  end

endmodule

// ----- dv/budgeted_stereo_fade_gate_tb.sv -----
// Testbench top for the budgeted stereo fade gate: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module budgeted_stereo_fade_gate_tb;
  import bsfg_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 250;
  localparam int SETTLE       = 150;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we;
  logic [RATE_W-1:0] cfg_wdata;
  int                err_cnt;
  int                pending;
  int                cycles = 0;
  int                items = 0;
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;
  bit                hold_req = 1'b0;
  int unsigned       cur_rate = RATE_RESET;

  bsfg_in_if  in_ch();
  bsfg_out_if out_ch();

  budgeted_stereo_fade_gate dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  budgeted_stereo_fade_gate_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_mon_i   (in_ch),
    .out_mon_i  (out_ch),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Downstream side: random stalls, or one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send(input logic [OPC_W-1:0] op, input logic signed [SAMPLE_W-1:0] l,
                      input logic signed [SAMPLE_W-1:0] r, input logic sk,
                      input logic [BUDGET_W-1:0] bc, input logic [US_W-1:0] us);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.left_in      <= l;
    in_ch.right_in     <= r;
    in_ch.sink_ready   <= sk;
    in_ch.budget_count <= bc;
    in_ch.fade_us      <= us;
    do @(posedge clk); while (!in_ch.ready);
    if (op <= OPC_STOP) items++;
  endtask

  task automatic play(input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] r,
                      input logic sk);
    send(OPC_SAMPLE, l, r, sk, $urandom, $urandom);
  endtask

  task automatic command(input logic [OPC_W-1:0] op, input logic [BUDGET_W-1:0] bc,
                         input logic [US_W-1:0] us);
    send(op, $urandom, $urandom, $urandom, bc, us);
  endtask

  // Waits until every predicted result has been seen; valid is low meanwhile.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (v != '0) cur_rate = v;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return -16'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly fade times that give short fades at the current rate, so fades finish.
  function automatic logic [US_W-1:0] pick_fade_us();
    longint unsigned t;
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return '0;
      default: begin
        t = (64'($urandom_range(1, 40)) * 64'(US_PER_S)) / cur_rate + $urandom_range(0, 3);
        if (t == 0) t = 1;
        if (t > 64'hFF_FFFF) t = 64'hFF_FFFF;
        return t[US_W-1:0];
      end
    endcase
  endfunction

  task automatic directed();
    play(16'sh7FFF, 16'sh8000, 1'b1);        // refused: no budget yet
    command(OPC_LOAD, 16'hFFFF, $urandom);
    play(16'sh7FFF, 16'sh8000, 1'b1);
    play(-16'sd1, 16'sd0, 1'b1);
    play(16'sh1234, -16'sd77, 1'b0);         // sink not ready
    play(16'sh5555, 16'shAAAA, 1'b1);
    command(OPC_FADE, $urandom, 24'd68);     // three-sample fade
    play(16'sh8000, 16'sh7FFF, 1'b1);
    play(16'sh7FFF, 16'sh8000, 1'b1);
    command(OPC_FADE, $urandom, 24'hFF_FFFF); // longest fade, step held at one
    play(16'sh8000, -16'sd1, 1'b1);
    command(OPC_FADE, $urandom, 24'd0);      // immediate mute
    play(16'sd12345, -16'sd12345, 1'b1);
    command(OPC_FADE, $urandom, 24'd100);    // fade from a muted envelope
    command(OPC_ENV_RESET, $urandom, $urandom);
    command(OPC_FADE, $urandom, 24'd1);      // one-sample fade
    play(16'sh7FFF, 16'sh8000, 1'b1);
    play(16'sh7FFF, 16'sh8000, 1'b1);
    command(OPC_STOP, $urandom, $urandom);
    play(16'sd1, -16'sd1, 1'b1);
    command(OPC_LOAD, 16'd1, $urandom);
    play(16'sh4000, 16'shC000, 1'b1);
    play(16'sh4000, 16'shC000, 1'b1);        // budget used up
    command(3'd5, $urandom, $urandom);
    command(3'd6, $urandom, $urandom);
    command(3'd7, $urandom, $urandom);
  endtask

  task automatic burst();
    int                  n;
    logic [OPC_W-1:0]    op;
    logic [BUDGET_W-1:0] bc;
    bc = $urandom_range(0, 60);
    if ($urandom_range(9) == 0) bc = $urandom;
    if ($urandom_range(99) < 70) command(OPC_LOAD, bc, $urandom);
    if ($urandom_range(99) < 60) command(OPC_FADE, $urandom, pick_fade_us());
    n = $urandom_range(1, 50);
    repeat (n) begin
      if ($urandom_range(99) < 5) begin
        op = $urandom_range(1, 7);
        command(op, $urandom, (op == OPC_FADE) ? pick_fade_us() : $urandom);
      end else begin
        play(pick_sample(), pick_sample(), $urandom_range(99) < 85);
      end
    end
    case ($urandom_range(9))
      0:       command(OPC_ENV_RESET, $urandom, $urandom);
      1:       command(OPC_STOP, $urandom, $urandom);
      default: ;
    endcase
  endtask

  initial begin
    logic [RATE_W-1:0] rates[6];
    int                target;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OPC_SAMPLE;
    in_ch.left_in      = '0;
    in_ch.right_in     = '0;
    in_ch.sink_ready   = 1'b0;
    in_ch.budget_count = '0;
    in_ch.fade_us      = '0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    rates = '{18'd1, 18'd192000, 18'd0, 18'd48000, 18'($urandom_range(2, 191999)), 18'd44100};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    drain();

    for (int p = 0; p < 6; p++) begin
      write_rate(rates[p]);
      src_idle_pct   = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 14 : 45) : 0;
      sink_stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 14 : 45) : 0;
      // The sender keeps going while the sink holds off, so the block backs up.
      if (p == 0) hold_req = 1'b1;
      target = items + PHASE_ITEMS;
      while (items < target) burst();
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bsfg_pkg.sv
hdl/bsfg_if.sv
hdl/bsfg_serial_mul.sv
hdl/bsfg_serial_div.sv
hdl/budgeted_stereo_fade_gate.sv
dv/budgeted_stereo_fade_gate_checker.sv
dv/budgeted_stereo_fade_gate_tb.sv
